// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and helpers for the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QueueDepthDef = 8;

  localparam int unsigned ColorW  = 8;
  localparam int unsigned KeyW    = 2 * ColorW;
  localparam int unsigned OccW    = 4;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 32;

  // operation selector carried on the input tuser
  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_e;

  // result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } color_t;

  // broadcast to every cell for one operation
  typedef struct packed {
    logic   enq;
    logic   deq;
    color_t ins;
  } cell_ctrl_t;

  // red is the primary key, blue breaks ties
  function automatic logic [KeyW-1:0] prio_key(input color_t c);
    prio_key = {c.red, c.blue};
  endfunction

endpackage

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain, shifts toward tail on insert, head on pop
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  spq_pkg::color_t     left_entry_i,
  input  logic                left_behind_i,
  input  spq_pkg::color_t     right_entry_i,
  output spq_pkg::color_t     entry_o,
  output logic                behind_o
);
  import spq_pkg::*;

  color_t entry_q, entry_d;

  // new entry lands at or ahead of this slot
  assign behind_o = !(occupied_i && (prio_key(entry_q) >= prio_key(ctrl_i.ins)));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.enq) begin
      if (left_behind_i) begin
        entry_d = left_entry_i;
      end else if (behind_o) begin
        entry_d = ctrl_i.ins;
      end
    end else if (ctrl_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// shift-register priority queue of rgb colors, kept sorted head first
// ----------------------------------------------------------------------------
// The queue is a row of QueueDepth cells, each holding one color. Every input
// transaction is one operation selected by s_axis_tuser: enqueue inserts the
// color behind all stored colors of equal or higher priority (higher red
// first, then higher blue; equal keys leave in arrival order), dequeue pops
// the head and every cell takes its right neighbor. All cells compare
// against the new key and shift in the same cycle, so one transaction is
// taken per clock unless the output stalls; the result is offered from an
// output register after acceptance, and the input stays ready while that
// register is empty or being drained, sustaining one operation per cycle.
// Every input transaction gives exactly one output transaction. An enqueue
// into a full queue returns status full and leaves the queue unchanged; a
// dequeue from an empty queue returns status empty. Color fields of a result
// are zero unless it is a successful dequeue. Occupancy is the count after
// the operation, low four bits. No clearing pass after reset is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int unsigned QueueDepth = spq_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  input  logic [spq_pkg::InDataW-1:0]    s_axis_tdata,
  // mode [0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_red [7:0], out_green [15:8], out_blue [23:16], occupancy [27:24], zero pad
  output logic [spq_pkg::OutDataW-1:0]   m_axis_tdata,
  // status [1:0]
  output logic [1:0]                     m_axis_tuser
);
  import spq_pkg::*;

  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned ExtW = (CntW > OccW) ? CntW : OccW;

  // entry count, the only control state of the row
  logic [CntW-1:0] cnt_q, cnt_d;

  // output register
  logic            out_vld_q;
  color_t          out_color_q, out_color_d;
  status_e         out_st_q, out_st_d;
  logic [CntW-1:0] out_cnt_q;

  logic       accept;
  logic       is_full;
  logic       is_empty;
  color_t     in_color;
  cell_ctrl_t ctrl;

  color_t entry [QueueDepth];
  logic   behind [QueueDepth];

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_color.red   = s_axis_tdata[7:0];
  assign in_color.green = s_axis_tdata[15:8];
  assign in_color.blue  = s_axis_tdata[23:16];

  assign is_full  = (cnt_q == CntW'(QueueDepth));
  assign is_empty = (cnt_q == '0);

  // broadcast the operation to the whole row
  always_comb begin
    ctrl.ins = in_color;
    ctrl.enq = accept && (s_axis_tuser == MODE_ENQ) && !is_full;
    ctrl.deq = accept && (s_axis_tuser == MODE_DEQ) && !is_empty;
  end

  // the row of cells
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    color_t left_entry;
    logic   left_behind;
    color_t right_entry;

    if (i == 0) begin : g_head
      assign left_entry  = in_color;
      assign left_behind = 1'b0;
    end else begin : g_mid
      assign left_entry  = entry[i-1];
      assign left_behind = behind[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_body
      assign right_entry = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (cnt_q > CntW'(i)),
      .left_entry_i  (left_entry),
      .left_behind_i (left_behind),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .behind_o      (behind[i])
    );
  end

  // count and result of the operation being accepted
  always_comb begin
    cnt_d       = cnt_q;
    out_color_d = '0;
    out_st_d    = ST_ENQ;
    unique case (s_axis_tuser)
      MODE_ENQ: begin
        if (is_full) begin
          out_st_d = ST_FULL;
        end else begin
          out_st_d = ST_ENQ;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      MODE_DEQ: begin
        if (is_empty) begin
          out_st_d = ST_EMPTY;
        end else begin
          out_st_d    = ST_DEQ;
          out_color_d = entry[0];
          cnt_d       = cnt_q - CntW'(1);
        end
      end
      default: begin
        out_st_d = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_color_q <= out_color_d;
      out_st_q    <= out_st_d;
      out_cnt_q   <= cnt_d;
    end
  end

  logic [ExtW-1:0] occ_ext;
  assign occ_ext = ExtW'(out_cnt_q);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {{(OutDataW - OccW - 3 * ColorW){1'b0}}, occ_ext[OccW-1:0],
                          out_color_q.blue, out_color_q.green, out_color_q.red};

endmodule

// ----- hdl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue
// ----------------------------------------------------------------------------
module spq_checker #(
  parameter int unsigned QueueDepth = spq_pkg::QueueDepthDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [spq_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                         s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [spq_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [1:0]                   m_axis_tuser
);
  import spq_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // colors only come with a successful pop
  a_zero_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_DEQ) |-> (m_axis_tdata[23:0] == '0))
    else $error("nonzero color on a non-pop result");

  // full rejection reports a full queue, empty rejection an empty one
  a_reject_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((m_axis_tuser != ST_FULL) || (m_axis_tdata[27:24] == 4'(QueueDepth))) &&
      ((m_axis_tuser != ST_EMPTY) || (m_axis_tdata[27:24] == 4'd0)))
    else $error("occupancy inconsistent with rejection status");

  // accepted input always leads to a result next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction gave no result");

endmodule

bind sorted_priority_queue spq_checker #(.QueueDepth(QueueDepth)) u_spq_checker (.*);
